// ===== src/lslf_pkg.sv =====
// Shared types, codes and defaults for the least-squares line fit core.
package lslf_pkg;

    localparam int DEF_MAX_PAIRS   = 4096;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int SQRT_BITS       = 15;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_pair;
    } lslf_in_t;

    typedef struct packed {
        logic signed [47:0] slope_q16;
        logic signed [47:0] intercept_q16;
        logic signed [15:0] correlation_q14;
        logic               fit_ok;
    } lslf_out_t;

    // Operand sources of the shared multiplier.
    typedef enum logic [3:0] {
        SRC_N, SRC_SX, SRC_SY, SRC_SXX, SRC_SYY, SRC_SXY,
        SRC_DXX, SRC_DYY, SRC_DXY, SRC_P, SRC_TT
    } lslf_src_t;

    // Destinations of a finished product.
    typedef enum logic [2:0] {
        DST_NONE, DST_DXX, DST_DYY, DST_DXY, DST_ANUM, DST_P, DST_RHS
    } lslf_dst_t;

    typedef struct packed {
        logic      acc;
        logic      clr;
        logic      mul_go;
        lslf_src_t mul_a;
        lslf_src_t mul_b;
        logic      mul_sub;
        lslf_dst_t mul_dst;
        logic      div_go;
        logic      div_icpt;
        logic      rhs_shift;
        logic      sqrt_init;
        logic      sqrt_step;
        logic      corr_one;
        logic      out_load;
        logic      out_fit;
    } lslf_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic dxx_pos;
        logic dyy_zero;
        logic sqrt_last;
        logic out_free;
    } lslf_sts_t;

endpackage

// ===== src/lslf_dp.sv =====
// Datapath: accumulators, shift-add multiplier, restoring divider, root search, output register.
module lslf_dp import lslf_pkg::*; #(
    parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  lslf_cmd_t cmd,
    output lslf_sts_t sts,
    input  lslf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lslf_out_t m_data
);

    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;
    localparam int DW = CW + QW + 2;
    localparam int W  = 2 * DW + 30;
    localparam int IW = $clog2(W);

    // Accumulators.
    logic        [CW-1:0] cnt_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [QW-1:0] sxx_reg, syy_reg, sxy_reg;

    logic signed [SAMPLE_BITS-1:0]   xs, ys;
    logic signed [2*SAMPLE_BITS-1:0] pxx, pyy, pxy;
    logic                            room;

    assign xs   = $signed(SAMPLE_BITS'($unsigned(s_data.x_sample)));
    assign ys   = $signed(SAMPLE_BITS'($unsigned(s_data.y_sample)));
    assign pxx  = xs * xs;
    assign pyy  = ys * ys;
    assign pxy  = xs * ys;
    assign room = cnt_reg < CW'(MAX_PAIRS);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr) begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end else if (cmd.acc && room) begin
            cnt_reg <= cnt_reg + CW'(1);
            sx_reg  <= sx_reg + SW'(xs);
            sy_reg  <= sy_reg + SW'(ys);
            sxx_reg <= sxx_reg + QW'(pxx);
            syy_reg <= syy_reg + QW'(pyy);
            sxy_reg <= sxy_reg + QW'(pxy);
        end
    end

    // Wide working registers.
    logic [W-1:0] dxx_reg, dyy_reg, dxy_reg, anum_reg, p_reg, rhs_reg;

    // Root search state.
    logic [SQRT_BITS-1:0]   k_reg, bit_reg, t_val;
    logic [2*SQRT_BITS-1:0] tt_val;

    assign t_val  = k_reg | bit_reg;
    assign tt_val = t_val * t_val;

    // Shift-add multiplier; products are taken modulo 2^W, which holds every
    // signed product that the fit needs.
    logic [W-1:0] ma_reg, mb_reg, macc_reg, macc_next, opa, opb, dst_cur, dst_val;
    logic         mbusy_reg, msub_reg;
    lslf_dst_t    mdst_reg;

    function automatic logic [W-1:0] pick(input lslf_src_t s,
                                          input logic [CW-1:0] n,
                                          input logic signed [SW-1:0] sx,
                                          input logic signed [SW-1:0] sy,
                                          input logic signed [QW-1:0] sxx,
                                          input logic signed [QW-1:0] syy,
                                          input logic signed [QW-1:0] sxy,
                                          input logic [W-1:0] dxx,
                                          input logic [W-1:0] dyy,
                                          input logic [W-1:0] dxy,
                                          input logic [W-1:0] p,
                                          input logic [2*SQRT_BITS-1:0] tt);
        logic [W-1:0] r;
        unique case (s)
            SRC_N:   r = W'(n);
            SRC_SX:  r = W'(sx);
            SRC_SY:  r = W'(sy);
            SRC_SXX: r = W'(sxx);
            SRC_SYY: r = W'(syy);
            SRC_SXY: r = W'(sxy);
            SRC_DXX: r = dxx;
            SRC_DYY: r = dyy;
            SRC_DXY: r = dxy;
            SRC_P:   r = p;
            SRC_TT:  r = W'(tt);
            default: r = '0;
        endcase
        return r;
    endfunction

    assign opa = pick(cmd.mul_a, cnt_reg, sx_reg, sy_reg, sxx_reg, syy_reg, sxy_reg,
                      dxx_reg, dyy_reg, dxy_reg, p_reg, tt_val);
    assign opb = pick(cmd.mul_b, cnt_reg, sx_reg, sy_reg, sxx_reg, syy_reg, sxy_reg,
                      dxx_reg, dyy_reg, dxy_reg, p_reg, tt_val);

    assign macc_next = mb_reg[0] ? macc_reg + ma_reg : macc_reg;

    always_comb begin
        unique case (mdst_reg)
            DST_DXX:  dst_cur = dxx_reg;
            DST_DYY:  dst_cur = dyy_reg;
            DST_DXY:  dst_cur = dxy_reg;
            DST_ANUM: dst_cur = anum_reg;
            DST_P:    dst_cur = p_reg;
            DST_RHS:  dst_cur = rhs_reg;
            default:  dst_cur = '0;
        endcase
        dst_val = msub_reg ? dst_cur - macc_next : macc_next;
    end

    assign sts.mul_done = mbusy_reg && ((mb_reg >> 1) == '0);

    // Restoring divider, one quotient bit per cycle; the divisor is dxx.
    logic [W-1:0]  dnum_reg, drem_reg, dq_reg, rem2, dsrc, dmag, qf;
    logic [IW-1:0] dcnt_reg;
    logic          dbusy_reg, dneg_reg, dicpt_reg, qbit, big;
    logic [47:0]   lim, mag48, dres;

    assign dsrc  = cmd.div_icpt ? anum_reg : dxy_reg;
    assign dmag  = dsrc[W-1] ? W'(0) - dsrc : dsrc;
    assign rem2  = {drem_reg[W-2:0], dnum_reg[W-1]};
    assign qbit  = rem2 >= dxx_reg;
    assign qf    = {dq_reg[W-2:0], qbit};
    assign lim   = dneg_reg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    assign big   = (qf[W-1:48] != '0) || (qf[47:0] > lim);
    assign mag48 = big ? lim : qf[47:0];
    assign dres  = dneg_reg ? 48'd0 - mag48 : mag48;

    assign sts.div_done = dbusy_reg && (dcnt_reg == '0);

    logic signed [47:0] slope_reg, icpt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
        end else begin
            if (cmd.mul_go) begin
                mbusy_reg <= 1'b1;
            end else if (sts.mul_done) begin
                mbusy_reg <= 1'b0;
            end
            if (cmd.div_go) begin
                dbusy_reg <= 1'b1;
            end else if (sts.div_done) begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            ma_reg   <= opa;
            mb_reg   <= opb;
            macc_reg <= '0;
            msub_reg <= cmd.mul_sub;
            mdst_reg <= cmd.mul_dst;
        end else if (mbusy_reg) begin
            ma_reg   <= ma_reg << 1;
            mb_reg   <= mb_reg >> 1;
            macc_reg <= macc_next;
        end

        if (sts.mul_done) begin
            unique case (mdst_reg)
                DST_DXX:  dxx_reg  <= dst_val;
                DST_DYY:  dyy_reg  <= dst_val;
                DST_DXY:  dxy_reg  <= dst_val;
                DST_ANUM: anum_reg <= dst_val;
                DST_P:    p_reg    <= dst_val;
                DST_RHS:  rhs_reg  <= dst_val;
                default: begin
                end
            endcase
        end else if (cmd.rhs_shift) begin
            rhs_reg <= rhs_reg << 28;
        end

        if (cmd.div_go) begin
            dnum_reg  <= dmag << 16;
            drem_reg  <= '0;
            dq_reg    <= '0;
            dcnt_reg  <= IW'(W - 1);
            dneg_reg  <= dsrc[W-1];
            dicpt_reg <= cmd.div_icpt;
        end else if (dbusy_reg) begin
            dnum_reg <= dnum_reg << 1;
            drem_reg <= qbit ? rem2 - dxx_reg : rem2;
            dq_reg   <= qf;
            dcnt_reg <= dcnt_reg - IW'(1);
            if (dcnt_reg == '0) begin
                if (dicpt_reg) begin
                    icpt_reg <= dres;
                end else begin
                    slope_reg <= dres;
                end
            end
        end

        // Largest k, at most 16384, with k*k*dxx*dyy no more than dxy*dxy*2^28, one bit a step.
        if (cmd.sqrt_init) begin
            k_reg   <= '0;
            bit_reg <= SQRT_BITS'(16384);
        end else if (cmd.corr_one) begin
            k_reg <= SQRT_BITS'(16384);
        end else if (cmd.sqrt_step) begin
            if (t_val <= SQRT_BITS'(16384) && macc_reg <= rhs_reg) begin
                k_reg <= t_val;
            end
            bit_reg <= bit_reg >> 1;
        end
    end

    assign sts.dxx_pos   = !dxx_reg[W-1] && (dxx_reg != '0);
    assign sts.dyy_zero  = dyy_reg == '0;
    assign sts.sqrt_last = bit_reg[0];

    // Output register.
    lslf_out_t   out_reg;
    logic        mvalid_reg;
    logic [15:0] kx;

    assign kx           = 16'(k_reg);
    assign sts.out_free = !mvalid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_ready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_fit) begin
                out_reg.slope_q16       <= slope_reg;
                out_reg.intercept_q16   <= icpt_reg;
                out_reg.correlation_q14 <= dxy_reg[W-1] ? 16'd0 - kx : kx;
                out_reg.fit_ok          <= 1'b1;
            end else begin
                out_reg <= '0;
            end
        end
    end

    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/lslf_ctrl.sv =====
// Controller: sequences accumulation, the final multiplies, divides and root search.
module lslf_ctrl import lslf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last,
    output logic      s_ready,
    input  lslf_sts_t sts,
    output lslf_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_ACC, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
        ST_CHK, ST_D1, ST_D2, ST_CK, ST_M9, ST_M10, ST_SH, ST_SQ, ST_STEP, ST_OUT
    } state_t;

    state_t state_reg;
    logic   launched_reg, fit_reg;
    logic   is_mul, is_div;

    always_comb begin
        cmd     = '0;
        is_mul  = 1'b0;
        is_div  = 1'b0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_ACC: begin
                s_ready = 1'b1;
                cmd.acc = s_valid;
            end
            ST_M1: begin
                is_mul = 1'b1; cmd.mul_a = SRC_N;  cmd.mul_b = SRC_SXX; cmd.mul_dst = DST_DXX;
            end
            ST_M2: begin
                is_mul = 1'b1; cmd.mul_a = SRC_SX; cmd.mul_b = SRC_SX;  cmd.mul_dst = DST_DXX;
                cmd.mul_sub = 1'b1;
            end
            ST_M3: begin
                is_mul = 1'b1; cmd.mul_a = SRC_N;  cmd.mul_b = SRC_SYY; cmd.mul_dst = DST_DYY;
            end
            ST_M4: begin
                is_mul = 1'b1; cmd.mul_a = SRC_SY; cmd.mul_b = SRC_SY;  cmd.mul_dst = DST_DYY;
                cmd.mul_sub = 1'b1;
            end
            ST_M5: begin
                is_mul = 1'b1; cmd.mul_a = SRC_N;  cmd.mul_b = SRC_SXY; cmd.mul_dst = DST_DXY;
            end
            ST_M6: begin
                is_mul = 1'b1; cmd.mul_a = SRC_SX; cmd.mul_b = SRC_SY;  cmd.mul_dst = DST_DXY;
                cmd.mul_sub = 1'b1;
            end
            ST_M7: begin
                is_mul = 1'b1; cmd.mul_a = SRC_SY; cmd.mul_b = SRC_SXX; cmd.mul_dst = DST_ANUM;
            end
            ST_M8: begin
                is_mul = 1'b1; cmd.mul_a = SRC_SX; cmd.mul_b = SRC_SXY; cmd.mul_dst = DST_ANUM;
                cmd.mul_sub = 1'b1;
            end
            ST_CHK: begin
            end
            ST_D1: begin
                is_div = 1'b1;
            end
            ST_D2: begin
                is_div = 1'b1; cmd.div_icpt = 1'b1;
            end
            ST_CK: begin
                cmd.corr_one = sts.dyy_zero;
            end
            ST_M9: begin
                is_mul = 1'b1; cmd.mul_a = SRC_DXX; cmd.mul_b = SRC_DYY; cmd.mul_dst = DST_P;
            end
            ST_M10: begin
                is_mul = 1'b1; cmd.mul_a = SRC_DXY; cmd.mul_b = SRC_DXY; cmd.mul_dst = DST_RHS;
            end
            ST_SH: begin
                cmd.rhs_shift = 1'b1;
                cmd.sqrt_init = 1'b1;
            end
            ST_SQ: begin
                is_mul = 1'b1; cmd.mul_a = SRC_TT; cmd.mul_b = SRC_P; cmd.mul_dst = DST_NONE;
            end
            ST_STEP: begin
                cmd.sqrt_step = 1'b1;
            end
            ST_OUT: begin
                cmd.out_load = sts.out_free;
                cmd.clr      = sts.out_free;
                cmd.out_fit  = fit_reg;
            end
            default: begin
            end
        endcase
        cmd.mul_go = is_mul && !launched_reg;
        cmd.div_go = is_div && !launched_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACC;
            launched_reg <= 1'b0;
            fit_reg      <= 1'b0;
        end else begin
            if (is_mul || is_div) begin
                if (!launched_reg) begin
                    launched_reg <= 1'b1;
                end else if ((is_mul && sts.mul_done) || (is_div && sts.div_done)) begin
                    launched_reg <= 1'b0;
                    unique case (state_reg)
                        ST_M1:   state_reg <= ST_M2;
                        ST_M2:   state_reg <= ST_M3;
                        ST_M3:   state_reg <= ST_M4;
                        ST_M4:   state_reg <= ST_M5;
                        ST_M5:   state_reg <= ST_M6;
                        ST_M6:   state_reg <= ST_M7;
                        ST_M7:   state_reg <= ST_M8;
                        ST_M8:   state_reg <= ST_CHK;
                        ST_D1:   state_reg <= ST_D2;
                        ST_D2:   state_reg <= ST_CK;
                        ST_M9:   state_reg <= ST_M10;
                        ST_M10:  state_reg <= ST_SH;
                        ST_SQ:   state_reg <= ST_STEP;
                        default: state_reg <= ST_ACC;
                    endcase
                end
            end else begin
                unique case (state_reg)
                    ST_ACC: begin
                        if (s_valid && s_last) begin
                            state_reg <= ST_M1;
                        end
                    end
                    ST_CHK: begin
                        fit_reg   <= sts.dxx_pos;
                        state_reg <= sts.dxx_pos ? ST_D1 : ST_OUT;
                    end
                    ST_CK: begin
                        state_reg <= sts.dyy_zero ? ST_OUT : ST_M9;
                    end
                    ST_SH: begin
                        state_reg <= ST_SQ;
                    end
                    ST_STEP: begin
                        state_reg <= sts.sqrt_last ? ST_OUT : ST_SQ;
                    end
                    ST_OUT: begin
                        if (sts.out_free) begin
                            state_reg <= ST_ACC;
                        end
                    end
                    default: state_reg <= ST_ACC;
                endcase
            end
        end
    end

endmodule

// ===== src/least_squares_line_fit_core.sv =====
// Top level of the least-squares straight-line fit core.
// The s_ channel carries (x, y) sample pairs with a last-pair flag; a
// transaction completes when s_valid and s_ready are both high. Each pair
// is added to the count and the sums of x, y, x*x, y*y and x*y in the cycle
// it is taken, one pair per cycle. Pairs beyond MAX_PAIRS are dropped.
// The pair that carries last_pair closes the data set: s_ready then falls
// while the fit is worked out by one shared shift-add multiplier and one
// restoring divider, each retiring one bit per cycle over a datapath of
// W = 2*(2*CW + 2*SAMPLE_BITS + 2) + 30 bits (CW = clog2(MAX_PAIRS+1)).
// Eight products, two divides, two more products and fifteen root-search
// products make up the fit; when dxx is not positive the rest is skipped,
// and a multiply ends early once its multiplier runs out of set bits.
// The result (slope, intercept, correlation, fit flag) sits in an output
// register on the m_ channel; the sums clear when it is loaded and new
// pairs are taken while it waits. If the receiver still stalls the previous
// result when the next one is ready, the core holds until it is taken.
// Reset (aresetn low at a clock edge) clears the sums and drops any result.
module least_squares_line_fit_core import lslf_pkg::*; #(
    parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lslf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lslf_out_t m_data
);

    lslf_cmd_t cmd;
    lslf_sts_t sts;

    lslf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_pair),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lslf_dp #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
